// File: rtl/sqh_pkg.sv
package sqh_pkg;

    // Field widths
    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 16;
    localparam int Q_W        = 32;   // perspective terms, Q16.16
    localparam int E_W        = 48;   // affine terms, Q32.16

    // Internal widths, all derived from the field widths above
    localparam int DIFF_W    = COORD_BITS + 1;        // two-corner difference
    localparam int CDIFF_W   = COORD_BITS + 2;        // four-corner difference
    localparam int DEN_W     = 2 * COORD_BITS + 3;    // products and denominator
    localparam int NUM_W     = 2 * COORD_BITS + 4;    // numerators
    localparam int INT_SHIFT = Q_W - FRAC_BITS;
    localparam int EXT_W     = NUM_W + INT_SHIFT;
    localparam int DIV_STEPS = Q_W;                   // one quotient bit per stage
    localparam int PROD_W    = Q_W + COORD_BITS;
    localparam int BASE_W    = COORD_BITS + 1 + FRAC_BITS;
    localparam int SUM_W     = ((PROD_W > BASE_W) ? PROD_W : BASE_W) + 1;

    // Register stages: setup, divider steps, sign fix, compose
    localparam int SETUP_STAGES = 5;
    localparam int PIPE_LATENCY = SETUP_STAGES + DIV_STEPS + 3;

    localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};
    localparam logic signed [E_W-1:0] E_MAX = {1'b0, {(E_W-1){1'b1}}};
    localparam logic signed [E_W-1:0] E_MIN = {1'b1, {(E_W-1){1'b0}}};

    typedef struct packed {
        logic signed [COORD_BITS-1:0] corner00_x;
        logic signed [COORD_BITS-1:0] corner00_y;
        logic signed [COORD_BITS-1:0] corner01_x;
        logic signed [COORD_BITS-1:0] corner01_y;
        logic signed [COORD_BITS-1:0] corner10_x;
        logic signed [COORD_BITS-1:0] corner10_y;
        logic signed [COORD_BITS-1:0] corner11_x;
        logic signed [COORD_BITS-1:0] corner11_y;
    } sqh_corners_t;

    typedef struct packed {
        logic signed [E_W-1:0] m11;
        logic signed [E_W-1:0] m12;
        logic signed [E_W-1:0] m13;
        logic signed [E_W-1:0] m21;
        logic signed [E_W-1:0] m22;
        logic signed [E_W-1:0] m23;
        logic signed [Q_W-1:0] m31;
        logic signed [Q_W-1:0] m32;
        logic                  degenerate;
        logic                  saturated;
    } sqh_matrix_t;

    // Corners needed after the divider
    typedef struct packed {
        logic signed [COORD_BITS-1:0] x00;
        logic signed [COORD_BITS-1:0] y00;
        logic signed [COORD_BITS-1:0] x01;
        logic signed [COORD_BITS-1:0] y01;
        logic signed [COORD_BITS-1:0] x10;
        logic signed [COORD_BITS-1:0] y10;
    } sqh_side_t;

    // One divider lane: partial remainder, feed bits shifting out / quotient in
    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [Q_W-1:0]   qf;
        logic             neg;
        logic             ovf;
    } sqh_lane_t;

    typedef struct packed {
        sqh_lane_t        lane31;
        sqh_lane_t        lane32;
        logic [DEN_W-1:0] dmag;
        logic             degenerate;
        sqh_side_t        side;
    } sqh_div_t;

    typedef struct packed {
        logic signed [Q_W-1:0] m31;
        logic signed [Q_W-1:0] m32;
        logic                  sat;
        logic                  degenerate;
        sqh_side_t             side;
    } sqh_persp_t;

endpackage

// File: rtl/sqh_setup.sv
module sqh_setup (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  sqh_pkg::sqh_corners_t corners,
    output logic                 out_valid,
    output sqh_pkg::sqh_div_t    out_data
);
    import sqh_pkg::*;

    // stage 1: corner differences
    logic signed [DIFF_W-1:0]  a_next, b_next, d_next, e_next;
    logic signed [CDIFF_W-1:0] c_next, f_next;
    logic signed [DIFF_W-1:0]  a_reg, b_reg, d_reg, e_reg;
    logic signed [CDIFF_W-1:0] c_reg, f_reg;
    sqh_side_t                 side_next;
    sqh_side_t                 side1_reg, side2_reg, side3_reg, side4_reg, side5_reg;
    logic                      v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    // stage 2: cross products
    logic signed [DEN_W-1:0] bd_reg, ae_reg, bf_reg, ce_reg, cd_reg, af_reg;

    // stage 3: denominator and numerators
    logic signed [DEN_W-1:0] den_reg;
    logic signed [NUM_W-1:0] n31_reg, n32_reg;

    // stage 4: magnitudes and signs
    logic [DEN_W-1:0] dmag_next, dmag4_reg, dmag5_reg;
    logic [NUM_W-1:0] nmag31_next, nmag32_next, nmag31_reg, nmag32_reg;
    logic             neg31_reg, neg32_reg, degen4_reg, degen5_reg;

    // stage 5: divider setup
    sqh_lane_t lane31_reg, lane32_reg;

    function automatic sqh_lane_t init_lane(
        input logic [NUM_W-1:0] nmag,
        input logic [DEN_W-1:0] dmag,
        input logic             neg
    );
        logic [EXT_W-1:0] wide;
        logic [EXT_W-1:0] upper;
        sqh_lane_t        l;
        wide  = EXT_W'(nmag);
        upper = wide >> INT_SHIFT;
        // integer part already too large for the signed Q format
        l.ovf = (upper >= EXT_W'(dmag));
        l.rem = l.ovf ? '0 : upper[DEN_W-1:0];
        l.qf  = {wide[INT_SHIFT-1:0], {FRAC_BITS{1'b0}}};
        l.neg = neg;
        return l;
    endfunction

    always_comb
    begin
        side_next.x00 = corners.corner00_x;
        side_next.y00 = corners.corner00_y;
        side_next.x01 = corners.corner01_x;
        side_next.y01 = corners.corner01_y;
        side_next.x10 = corners.corner10_x;
        side_next.y10 = corners.corner10_y;
        a_next = DIFF_W'(corners.corner10_x) - DIFF_W'(corners.corner11_x);
        b_next = DIFF_W'(corners.corner01_x) - DIFF_W'(corners.corner11_x);
        d_next = DIFF_W'(corners.corner10_y) - DIFF_W'(corners.corner11_y);
        e_next = DIFF_W'(corners.corner01_y) - DIFF_W'(corners.corner11_y);
        c_next = CDIFF_W'(corners.corner00_x) - CDIFF_W'(corners.corner01_x)
               - CDIFF_W'(corners.corner10_x) + CDIFF_W'(corners.corner11_x);
        f_next = CDIFF_W'(corners.corner00_y) - CDIFF_W'(corners.corner01_y)
               - CDIFF_W'(corners.corner10_y) + CDIFF_W'(corners.corner11_y);
    end

    always_comb
    begin
        dmag_next   = den_reg[DEN_W-1] ? DEN_W'(-den_reg) : DEN_W'(den_reg);
        nmag31_next = n31_reg[NUM_W-1] ? NUM_W'(-n31_reg) : NUM_W'(n31_reg);
        nmag32_next = n32_reg[NUM_W-1] ? NUM_W'(-n32_reg) : NUM_W'(n32_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        b_reg     <= b_next;
        c_reg     <= c_next;
        d_reg     <= d_next;
        e_reg     <= e_next;
        f_reg     <= f_next;
        side1_reg <= side_next;

        bd_reg    <= DEN_W'(b_reg) * DEN_W'(d_reg);
        ae_reg    <= DEN_W'(a_reg) * DEN_W'(e_reg);
        bf_reg    <= DEN_W'(b_reg) * DEN_W'(f_reg);
        ce_reg    <= DEN_W'(c_reg) * DEN_W'(e_reg);
        cd_reg    <= DEN_W'(c_reg) * DEN_W'(d_reg);
        af_reg    <= DEN_W'(a_reg) * DEN_W'(f_reg);
        side2_reg <= side1_reg;

        den_reg   <= bd_reg - ae_reg;
        n31_reg   <= NUM_W'(bf_reg) - NUM_W'(ce_reg);
        n32_reg   <= NUM_W'(cd_reg) - NUM_W'(af_reg);
        side3_reg <= side2_reg;

        dmag4_reg  <= dmag_next;
        nmag31_reg <= nmag31_next;
        nmag32_reg <= nmag32_next;
        neg31_reg  <= n31_reg[NUM_W-1] ^ den_reg[DEN_W-1];
        neg32_reg  <= n32_reg[NUM_W-1] ^ den_reg[DEN_W-1];
        degen4_reg <= (den_reg == '0);
        side4_reg  <= side3_reg;

        lane31_reg <= init_lane(nmag31_reg, dmag4_reg, neg31_reg);
        lane32_reg <= init_lane(nmag32_reg, dmag4_reg, neg32_reg);
        dmag5_reg  <= dmag4_reg;
        degen5_reg <= degen4_reg;
        side5_reg  <= side4_reg;
    end

    assign out_valid           = v5_reg;
    assign out_data.lane31     = lane31_reg;
    assign out_data.lane32     = lane32_reg;
    assign out_data.dmag       = dmag5_reg;
    assign out_data.degenerate = degen5_reg;
    assign out_data.side       = side5_reg;

endmodule

// File: rtl/sqh_divider.sv
module sqh_divider (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  sqh_pkg::sqh_div_t   in_data,
    output logic                out_valid,
    output sqh_pkg::sqh_persp_t out_data
);
    import sqh_pkg::*;

    typedef struct packed {
        logic signed [Q_W-1:0] value;
        logic                  sat;
    } sqh_fix_t;

    sqh_div_t   src_data [DIV_STEPS];
    logic       src_v    [DIV_STEPS];
    sqh_div_t   pipe_reg [DIV_STEPS];
    logic       v_reg    [DIV_STEPS];
    sqh_fix_t   fix31, fix32;
    sqh_persp_t out_reg;
    logic       out_v_reg;

    // restoring step: shift in one feed bit, subtract divisor if it fits
    function automatic sqh_lane_t lane_step(input sqh_lane_t l, input logic [DEN_W-1:0] dm);
        logic [DEN_W:0] t;
        logic [DEN_W:0] diff;
        logic           take;
        sqh_lane_t      r;
        t    = {l.rem, l.qf[Q_W-1]};
        diff = t - {1'b0, dm};
        take = (t >= {1'b0, dm});
        r     = l;
        r.rem = take ? diff[DEN_W-1:0] : t[DEN_W-1:0];
        r.qf  = {l.qf[Q_W-2:0], take};
        return r;
    endfunction

    function automatic sqh_div_t div_step(input sqh_div_t s);
        sqh_div_t r;
        r        = s;
        r.lane31 = lane_step(s.lane31, s.dmag);
        r.lane32 = lane_step(s.lane32, s.dmag);
        return r;
    endfunction

    // apply sign, clamp to the signed Q range
    function automatic sqh_fix_t fix_lane(input sqh_lane_t l);
        sqh_fix_t f;
        f.sat   = 1'b0;
        f.value = l.qf;
        if (l.ovf)
        begin
            f.sat   = 1'b1;
            f.value = l.neg ? Q_MIN : Q_MAX;
        end
        else if (!l.neg)
        begin
            if (l.qf[Q_W-1])
            begin
                f.sat   = 1'b1;
                f.value = Q_MAX;
            end
        end
        else if (l.qf[Q_W-1] && (|l.qf[Q_W-2:0]))
        begin
            f.sat   = 1'b1;
            f.value = Q_MIN;
        end
        else
        begin
            f.value = -l.qf;
        end
        return f;
    endfunction

    assign src_data[0] = in_data;
    assign src_v[0]    = in_valid;

    for (genvar s = 1; s < DIV_STEPS; s++)
    begin : g_link
        assign src_data[s] = pipe_reg[s-1];
        assign src_v[s]    = v_reg[s-1];
    end

    for (genvar s = 0; s < DIV_STEPS; s++)
    begin : g_step
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s] <= 1'b0;
            end
            else
            begin
                v_reg[s] <= src_v[s];
            end
        end

        always_ff @(posedge clk)
        begin
            pipe_reg[s] <= div_step(src_data[s]);
        end
    end

    always_comb
    begin
        fix31 = fix_lane(pipe_reg[DIV_STEPS-1].lane31);
        fix32 = fix_lane(pipe_reg[DIV_STEPS-1].lane32);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else
        begin
            out_v_reg <= v_reg[DIV_STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg.m31        <= fix31.value;
        out_reg.m32        <= fix32.value;
        out_reg.sat        <= fix31.sat | fix32.sat;
        out_reg.degenerate <= pipe_reg[DIV_STEPS-1].degenerate;
        out_reg.side       <= pipe_reg[DIV_STEPS-1].side;
    end

    assign out_valid = out_v_reg;
    assign out_data  = out_reg;

endmodule

// File: rtl/sqh_compose.sv
module sqh_compose (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  sqh_pkg::sqh_persp_t  in_data,
    output logic                 out_valid,
    output sqh_pkg::sqh_matrix_t out_data
);
    import sqh_pkg::*;

    typedef struct packed {
        logic signed [E_W-1:0] value;
        logic                  sat;
    } sqh_clip_t;

    // stage A: products, scaled corner differences and scaled corner00 offsets
    logic signed [PROD_W-1:0] p11_reg, p12_reg, p21_reg, p22_reg;
    logic signed [BASE_W-1:0] b11_reg, b12_reg, b21_reg, b22_reg, b13_reg, b23_reg;
    logic signed [Q_W-1:0]    m31_reg, m32_reg;
    logic                     sat_a_reg, degen_a_reg, va_reg;

    // stage B: sums, clipping, degenerate override
    sqh_clip_t   c11, c12, c13, c21, c22, c23;
    sqh_matrix_t res_next, res_reg;
    logic        vb_reg;

    function automatic sqh_clip_t clip_e(input logic signed [SUM_W-1:0] v);
        sqh_clip_t c;
        logic      in_range;
        in_range = (&v[SUM_W-1:E_W-1]) | ~(|v[SUM_W-1:E_W-1]);
        c.sat    = ~in_range;
        c.value  = in_range ? v[E_W-1:0] : (v[SUM_W-1] ? E_MIN : E_MAX);
        return c;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p11_reg <= PROD_W'(in_data.m31) * PROD_W'(in_data.side.x10);
        p21_reg <= PROD_W'(in_data.m31) * PROD_W'(in_data.side.y10);
        p12_reg <= PROD_W'(in_data.m32) * PROD_W'(in_data.side.x01);
        p22_reg <= PROD_W'(in_data.m32) * PROD_W'(in_data.side.y01);
        b11_reg <= BASE_W'(DIFF_W'(in_data.side.x10) - DIFF_W'(in_data.side.x00)) <<< FRAC_BITS;
        b12_reg <= BASE_W'(DIFF_W'(in_data.side.x01) - DIFF_W'(in_data.side.x00)) <<< FRAC_BITS;
        b21_reg <= BASE_W'(DIFF_W'(in_data.side.y10) - DIFF_W'(in_data.side.y00)) <<< FRAC_BITS;
        b22_reg <= BASE_W'(DIFF_W'(in_data.side.y01) - DIFF_W'(in_data.side.y00)) <<< FRAC_BITS;
        b13_reg <= BASE_W'(in_data.side.x00) <<< FRAC_BITS;
        b23_reg <= BASE_W'(in_data.side.y00) <<< FRAC_BITS;
        m31_reg     <= in_data.m31;
        m32_reg     <= in_data.m32;
        sat_a_reg   <= in_data.sat;
        degen_a_reg <= in_data.degenerate;
    end

    always_comb
    begin
        c11 = clip_e(SUM_W'(b11_reg) + SUM_W'(p11_reg));
        c12 = clip_e(SUM_W'(b12_reg) + SUM_W'(p12_reg));
        c21 = clip_e(SUM_W'(b21_reg) + SUM_W'(p21_reg));
        c22 = clip_e(SUM_W'(b22_reg) + SUM_W'(p22_reg));
        c13 = clip_e(SUM_W'(b13_reg));
        c23 = clip_e(SUM_W'(b23_reg));

        res_next = '0;
        if (degen_a_reg)
        begin
            res_next.degenerate = 1'b1;
        end
        else
        begin
            res_next.m11       = c11.value;
            res_next.m12       = c12.value;
            res_next.m13       = c13.value;
            res_next.m21       = c21.value;
            res_next.m22       = c22.value;
            res_next.m23       = c23.value;
            res_next.m31       = m31_reg;
            res_next.m32       = m32_reg;
            res_next.saturated = sat_a_reg | c11.sat | c12.sat | c13.sat
                               | c21.sat | c22.sat | c23.sat;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign out_valid = vb_reg;
    assign out_data  = res_reg;

endmodule

// File: rtl/square_to_quad_homography_core.sv
// Square-to-quad projective mapping core.
//
// Input: the four quad corners as one packed item on corners, taken at a rising
// edge with start high and busy low. busy is held low: the core takes one item
// every cycle, back to back, with any number of idle cycles between items.
// Output: the eight free matrix entries plus degenerate / saturated flags on
// result, marked by done for exactly one cycle. One result per item, in order.
//
// The pipeline runs from the accepting edge to the edge that takes the result
// through 5 setup stages (corner differences, cross products, determinant
// and numerators, magnitudes, divider setup), 32 divider stages that each
// retire one quotient bit of the two perspective terms against the shared
// denominator, one sign/clamp stage and 2 compose stages (multiply, add+clip).
// Throughput is one item per cycle.
//
// Reset clears only the valid bits of the pipeline; items in flight are
// dropped. The receiver cannot stall, so nothing in the pipe ever waits.
module square_to_quad_homography_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  sqh_pkg::sqh_corners_t corners,
    output logic                  done,
    output sqh_pkg::sqh_matrix_t  result
);
    import sqh_pkg::*;

    logic       accept;
    logic       setup_valid;
    sqh_div_t   setup_data;
    logic       div_valid;
    sqh_persp_t div_data;

    // no backpressure anywhere in the pipe
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // differences, determinants, operand magnitudes
    sqh_setup u_setup (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .corners   (corners),
        .out_valid (setup_valid),
        .out_data  (setup_data)
    );

    // two bit-per-stage quotients sharing the denominator, then Q16.16 clamp
    sqh_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (setup_valid),
        .in_data   (setup_data),
        .out_valid (div_valid),
        .out_data  (div_data)
    );

    // affine entries from the clamped perspective terms; degenerate zeroing
    sqh_compose u_compose (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid),
        .in_data   (div_data),
        .out_valid (done),
        .out_data  (result)
    );

endmodule

// File: rtl/sqh_checker.sv
module sqh_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  start,
    input logic                  busy,
    input sqh_pkg::sqh_corners_t corners,
    input logic                  done,
    input sqh_pkg::sqh_matrix_t  result
);
    import sqh_pkg::*;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##PIPE_LATENCY done)
        else $error("accepted item gave no result at fixed latency");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##PIPE_LATENCY !done)
        else $error("result without an accepted item");

    a_degenerate: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.degenerate) |->
            (result.m11 == '0 && result.m12 == '0 && result.m13 == '0 &&
             result.m21 == '0 && result.m22 == '0 && result.m23 == '0 &&
             result.m31 == '0 && result.m32 == '0 && !result.saturated))
        else $error("degenerate result not cleared");

    a_offset: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.degenerate) |->
            (result.m13 == (E_W'($past(corners.corner00_x, PIPE_LATENCY)) <<< FRAC_BITS) &&
             result.m23 == (E_W'($past(corners.corner00_y, PIPE_LATENCY)) <<< FRAC_BITS)))
        else $error("translation column does not match corner00");

endmodule

bind square_to_quad_homography_core sqh_checker u_sqh_checker (.*);
